// ===== src/u8dec_pkg.sv =====
// shared types, error codes and lead byte tables for the utf-8 stream decoder
// no dependencies
`default_nettype none

package u8dec_pkg;

	localparam int CP_W = 21;

	typedef logic [2:0] err_code_t;

	localparam err_code_t ERR_NONE        = 3'd0;
	localparam err_code_t ERR_TRUNC_START = 3'd1;
	localparam err_code_t ERR_TRUNC_END   = 3'd2;
	localparam err_code_t ERR_BAD_2BYTE   = 3'd3;
	localparam err_code_t ERR_BAD_3BYTE   = 3'd4;
	localparam err_code_t ERR_BAD_4BYTE   = 3'd5;
	localparam err_code_t ERR_BAD_LEAD    = 3'd6;
	localparam err_code_t ERR_NON_ASCII   = 3'd7;

	typedef struct packed {
		logic            has_char;
		logic [CP_W-1:0] code_point;
		logic [2:0]      char_bytes;
		err_code_t       error_code;
		logic            end_of_string;
	} res_t;

	// sequence length by high nibble of the lead byte
	localparam logic [2:0] LEN_OF_NIBBLE [16] = '{
		3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
		3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4
	};

	function automatic logic [7:0] lead_mask(input logic [2:0] len);
		logic [7:0] m;
		unique case (len)
			3'd1:    m = 8'h7F;
			3'd2:    m = 8'h1F;
			3'd3:    m = 8'h0F;
			3'd4:    m = 8'h07;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== src/utf8_stream_validate_decode_top.sv =====
// a result is registered in the output register, or in the skid stage when that stalls
// throughput: one byte per cycle; in_stall rises only when the output register and
// its skid stage both hold results that the sink has not taken
// reset (arst_n low): string state to start of string, ascii_only cleared, no results held
// cfg_ready is always high; a write takes effect from the next accepted byte
// depends on u8dec_pkg and u8dec_core
`default_nettype none

module utf8_stream_validate_decode_top
	import u8dec_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic            cfg_ascii_only,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic [7:0]      in_byte,
	input  wire logic            last_byte,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic                 has_char,
	output logic [CP_W-1:0]      code_point,
	output logic [2:0]           char_bytes,
	output logic [2:0]           error_code,
	output logic                 end_of_string
);

	logic ascii_only_q;
	logic accept;
	logic produce;
	res_t res_new;
	res_t out_q;
	res_t skid_q;
	logic out_valid_q;
	logic skid_valid_q;
	logic take;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_valid_q;
	assign accept    = in_valid & ~skid_valid_q;
	assign take      = out_valid_q & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ascii_only_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			ascii_only_q <= cfg_ascii_only;
		end
	end

	u8dec_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (accept),
		.in_byte    (in_byte),
		.last_byte  (last_byte),
		.ascii_only (ascii_only_q),
		.produce    (produce),
		.res        (res_new)
	);

	// output register plus skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept && produce) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (accept && produce) begin
			if (out_valid_q && !take) begin
				skid_q <= res_new;
			end else begin
				out_q <= res_new;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign has_char      = out_q.has_char;
	assign code_point    = out_q.code_point;
	assign char_bytes    = out_q.char_bytes;
	assign error_code    = out_q.error_code;
	assign end_of_string = out_q.end_of_string;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage holds an item while output register is empty");

	a_no_char_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.has_char |-> (out_q.char_bytes == 3'd0 && out_q.code_point == '0))
		else $error("character fields set without a character");

	a_err_excl_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.error_code != ERR_NONE |-> !out_q.has_char)
		else $error("error reported together with a character");

	a_char_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.has_char |-> (out_q.char_bytes >= 3'd1 && out_q.char_bytes <= 3'd4))
		else $error("character with a length outside one to four bytes");

endmodule

`default_nettype wire

// ===== src/u8dec_core.sv =====
// per-byte decode step: string state registers and the result of one item
// depends on u8dec_pkg
`default_nettype none

module u8dec_core
	import u8dec_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] in_byte,
	input  wire logic       last_byte,
	input  wire logic       ascii_only,
	output logic            produce,
	output res_t            res
);

	logic [1:0]      bytes_left_q, bytes_left_d;
	logic [2:0]      seq_len_q, seq_len_d;
	logic [CP_W-1:0] partial_q, partial_d;
	logic            bad_cont_q, bad_cont_d;
	logic            at_start_q, at_start_d;
	logic            err_latched_q, err_latched_d;

	always_comb begin
		logic [2:0]      n;
		logic [2:0]      bl_dec;
		err_code_t       err;
		logic            got_char;
		logic [CP_W-1:0] cp;
		logic [2:0]      nb;
		logic            is_cont;

		bytes_left_d  = bytes_left_q;
		seq_len_d     = seq_len_q;
		partial_d     = partial_q;
		bad_cont_d    = bad_cont_q;
		at_start_d    = at_start_q;
		err_latched_d = err_latched_q;
		produce       = 1'b0;
		res           = '0;
		err           = ERR_NONE;
		got_char      = 1'b0;
		cp            = '0;
		nb            = '0;
		is_cont       = (in_byte[7:6] == 2'b10);
		n             = LEN_OF_NIBBLE[in_byte[7:4]];
		bl_dec        = {1'b0, bytes_left_q - 2'd1};

		if (err_latched_q) begin
			if (last_byte) begin
				produce           = 1'b1;
				res.end_of_string = 1'b1;
			end
		end else begin
			priority if (ascii_only && in_byte[7]) begin
				err = ERR_NON_ASCII;
			end else if (bytes_left_q == 2'd0) begin
				priority if (at_start_q && is_cont) begin
					err = ERR_TRUNC_START;
				end else if (!in_byte[7]) begin
					got_char = 1'b1;
					cp       = CP_W'(in_byte);
					nb       = 3'd1;
				end else if (n == 3'd1) begin
					err = ERR_BAD_LEAD;
				end else if (last_byte) begin
					err = ERR_TRUNC_END;
				end else begin
					seq_len_d    = n;
					bytes_left_d = 2'(n - 3'd1);
					partial_d    = CP_W'(in_byte & lead_mask(n));
					bad_cont_d   = 1'b0;
				end
			end else begin
				bytes_left_d = bl_dec[1:0];
				if (bl_dec == 3'd0) begin
					// sequence complete: report bad continuation by length
					if (bad_cont_q || !is_cont) begin
						if (seq_len_q >= 3'd2 && seq_len_q <= 3'd4) begin
							err = seq_len_q + 3'd1;
						end else begin
							err = ERR_BAD_LEAD;
						end
					end else begin
						got_char = 1'b1;
						cp       = {partial_q[CP_W-7:0], in_byte[5:0]};
						nb       = seq_len_q;
					end
					seq_len_d  = '0;
					partial_d  = '0;
					bad_cont_d = 1'b0;
				end else begin
					partial_d  = {partial_q[CP_W-7:0], in_byte[5:0]};
					bad_cont_d = bad_cont_q | ~is_cont;
					if (last_byte) begin
						err = ERR_TRUNC_END;
					end
				end
			end
			at_start_d = 1'b0;
			if (err != ERR_NONE) begin
				produce           = 1'b1;
				res.error_code    = err;
				res.end_of_string = last_byte;
				err_latched_d     = ~last_byte;
			end else if (got_char || last_byte) begin
				produce           = 1'b1;
				res.has_char      = got_char;
				res.code_point    = cp;
				res.char_bytes    = nb;
				res.end_of_string = last_byte;
			end
		end

		// end of string returns every string register to its reset value
		if (last_byte) begin
			bytes_left_d  = '0;
			seq_len_d     = '0;
			partial_d     = '0;
			bad_cont_d    = 1'b0;
			at_start_d    = 1'b1;
			err_latched_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q  <= '0;
			seq_len_q     <= '0;
			partial_q     <= '0;
			bad_cont_q    <= 1'b0;
			at_start_q    <= 1'b1;
			err_latched_q <= 1'b0;
		end else if (step) begin
			bytes_left_q  <= bytes_left_d;
			seq_len_q     <= seq_len_d;
			partial_q     <= partial_d;
			bad_cont_q    <= bad_cont_d;
			at_start_q    <= at_start_d;
			err_latched_q <= err_latched_d;
		end
	end

	a_open_seq_len: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_left_q != 2'd0 |-> (seq_len_q >= 3'd2 && seq_len_q <= 3'd4))
		else $error("open sequence without a valid length");

	a_left_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_left_q != 2'd0 |-> {1'b0, bytes_left_q} < seq_len_q)
		else $error("more continuation bytes left than the sequence holds");

	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		at_start_q |-> (bytes_left_q == 2'd0 && !err_latched_q))
		else $error("string start with open sequence or latched error");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// testbench for utf8_stream_validate_decode_top: directed and random byte strings,
// each result checked against an in-bench decoder model, with random gaps and stalls
// depends on u8dec_pkg and utf8_stream_validate_decode_top
`timescale 1ns / 1ps

module tb;
	import u8dec_pkg::*;

	typedef logic [7:0] u8_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic            cfg_ascii_only = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	u8_t             in_byte = 8'h00;
	logic            last_byte = 1'b0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	logic            has_char;
	logic [CP_W-1:0] code_point;
	logic [2:0]      char_bytes;
	logic [2:0]      error_code;
	logic            end_of_string;

	utf8_stream_validate_decode_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_ascii_only(cfg_ascii_only),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.has_char      (has_char),
		.code_point    (code_point),
		.char_bytes    (char_bytes),
		.error_code    (error_code),
		.end_of_string (end_of_string)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// decoder model state
	logic            ascii_mode = 1'b0;
	logic [1:0]      dec_left = 2'd0;
	logic [2:0]      dec_len = 3'd0;
	logic [CP_W-1:0] dec_acc = '0;
	logic            dec_bad = 1'b0;
	logic            dec_at_start = 1'b1;
	logic            dec_err_held = 1'b0;

	res_t decoded_q[$];
	u8_t  string_bytes[$];
	int   mismatches = 0;
	int   bytes_sent = 0;
	int   src_idle_pct = 0;
	int   snk_stall_pct = 0;

	function automatic void restart_string();
		dec_left = 2'd0;
		dec_len = 3'd0;
		dec_acc = '0;
		dec_bad = 1'b0;
		dec_at_start = 1'b1;
		dec_err_held = 1'b0;
	endfunction

	function automatic void decode_byte(input u8_t b, input logic last);
		res_t            r;
		err_code_t       err;
		logic            got;
		logic [2:0]      n;
		logic [CP_W-1:0] cp;
		logic [2:0]      nb;
		r = '0;
		err = ERR_NONE;
		got = 1'b0;
		cp = '0;
		nb = 3'd0;
		// after the first error only the last byte of the string yields an item
		if (dec_err_held) begin
			if (last) begin
				r.end_of_string = 1'b1;
				decoded_q.insert(decoded_q.size(), r);
				restart_string();
			end
			return;
		end
		if (ascii_mode && b[7]) begin
			err = ERR_NON_ASCII;
		end else if (dec_left == 2'd0) begin
			if (dec_at_start && b[7:6] == 2'b10) begin
				err = ERR_TRUNC_START;
			end else if (!b[7]) begin
				got = 1'b1;
				cp = CP_W'(b);
				nb = 3'd1;
			end else begin
				case (b[7:4])
					4'hC, 4'hD: n = 3'd2;
					4'hE:       n = 3'd3;
					4'hF:       n = 3'd4;
					default:    n = 3'd1;
				endcase
				if (n == 3'd1) begin
					err = ERR_BAD_LEAD;
				end else if (last) begin
					err = ERR_TRUNC_END;
				end else begin
					dec_len = n;
					dec_left = 2'(n - 3'd1);
					dec_bad = 1'b0;
					case (n)
						3'd2:    dec_acc = CP_W'(b & 8'h1F);
						3'd3:    dec_acc = CP_W'(b & 8'h0F);
						default: dec_acc = CP_W'(b & 8'h07);
					endcase
				end
			end
		end else begin
			if (b[7:6] != 2'b10)
				dec_bad = 1'b1;
			dec_acc = {dec_acc[CP_W-7:0], b[5:0]};
			dec_left = dec_left - 2'd1;
			if (dec_left == 2'd0) begin
				if (dec_bad) begin
					err = (dec_len == 3'd2) ? ERR_BAD_2BYTE :
						(dec_len == 3'd3) ? ERR_BAD_3BYTE : ERR_BAD_4BYTE;
				end else begin
					got = 1'b1;
					cp = dec_acc;
					nb = dec_len;
				end
				dec_len = 3'd0;
				dec_acc = '0;
				dec_bad = 1'b0;
			end else if (last) begin
				// a cut-off sequence is truncated even when also mis-encoded
				err = ERR_TRUNC_END;
			end
		end
		dec_at_start = 1'b0;
		if (err != ERR_NONE) begin
			r.error_code = err;
			r.end_of_string = last;
			decoded_q.insert(decoded_q.size(), r);
			if (last)
				restart_string();
			else
				dec_err_held = 1'b1;
		end else if (got || last) begin
			r.has_char = got;
			r.code_point = cp;
			r.char_bytes = nb;
			r.end_of_string = last;
			decoded_q.insert(decoded_q.size(), r);
			if (last)
				restart_string();
		end
	endfunction

	task automatic flag_mismatch(input string msg);
		if (mismatches < 100)
			$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// result side: random stall and compare against the oldest expectation
	always @(posedge clk) begin : result_check
		res_t want;
		out_stall <= ($urandom_range(0, 99) < snk_stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected item: cp %0h err %0d eos %0b",
					code_point, error_code, end_of_string));
			end else begin
				want = decoded_q.pop_front();
				if (has_char !== want.has_char)
					flag_mismatch($sformatf("has_char %0b, want %0b",
						has_char, want.has_char));
				if (code_point !== want.code_point)
					flag_mismatch($sformatf("code_point %0h, want %0h",
						code_point, want.code_point));
				if (char_bytes !== want.char_bytes)
					flag_mismatch($sformatf("char_bytes %0d, want %0d",
						char_bytes, want.char_bytes));
				if (error_code !== want.error_code)
					flag_mismatch($sformatf("error_code %0d, want %0d",
						error_code, want.error_code));
				if (end_of_string !== want.end_of_string)
					flag_mismatch($sformatf("end_of_string %0b, want %0b",
						end_of_string, want.end_of_string));
			end
		end
	end

	task automatic send_byte(input u8_t b, input logic last);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (in_stall);
		decode_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_string();
		foreach (string_bytes[i])
			send_byte(string_bytes[i], i == string_bytes.size() - 1);
	endtask

	// hold the input until every expected item has come out
	task automatic drain();
		in_valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
	endtask

	// also covers bytes that leave no item behind
	task automatic quiesce();
		drain();
		repeat (3) @(posedge clk);
	endtask

	task automatic write_ascii_only(input logic v);
		cfg_valid <= 1'b1;
		cfg_ascii_only <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ascii_mode = v;
	endtask

	task automatic push_cont(input int count);
		repeat (count)
			string_bytes.insert(string_bytes.size(), 8'h80 | 8'($urandom_range(0, 63)));
	endtask

	task automatic build_random_string(input logic ascii_heavy);
		int r;
		int kind;
		int k;
		string_bytes.delete();
		r = $urandom_range(0, 99);
		if (r >= 94) begin
			// pure noise
			repeat ($urandom_range(1, 6))
				string_bytes.insert(string_bytes.size(), 8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(1, 6)) begin
			kind = $urandom_range(0, 9);
			if (ascii_heavy && kind < 8)
				kind = 0;
			case (kind)
				0, 1, 2, 3: string_bytes.insert(string_bytes.size(),
					8'($urandom_range(0, 127)));
				4, 5: begin
					string_bytes.insert(string_bytes.size(),
						8'hC0 | 8'($urandom_range(0, 31)));
					push_cont(1);
				end
				6, 7: begin
					string_bytes.insert(string_bytes.size(),
						8'hE0 | 8'($urandom_range(0, 15)));
					push_cont(2);
				end
				8: begin
					// includes f8-ff leads
					string_bytes.insert(string_bytes.size(),
						8'hF0 | 8'($urandom_range(0, 15)));
					push_cont(3);
				end
				default: string_bytes.insert(string_bytes.size(),
					8'($urandom_range(0, 255)));
			endcase
		end
		if (r >= 70 && r < 80) begin
			string_bytes[$urandom_range(0, string_bytes.size() - 1)] =
				8'($urandom_range(0, 255));
		end else if (r >= 80 && r < 88) begin
			k = $urandom_range(1, 2);
			while (k > 0 && string_bytes.size() > 1) begin
				void'(string_bytes.pop_back());
				k--;
			end
		end else if (r >= 88) begin
			string_bytes.insert($urandom_range(0, string_bytes.size() - 1),
				8'h80 | 8'($urandom_range(0, 63)));
		end
	endtask

	task automatic test_directed_utf8();
		quiesce();
		write_ascii_only(1'b0);
		string_bytes = '{8'h00, 8'h7F};
		send_string();
		// f8-ff lead taken as 4-byte, largest code point
		string_bytes = '{8'hFF, 8'hBF, 8'hBF, 8'hBF};
		send_string();
		// continuation at string start, rest ignored
		string_bytes = '{8'h80, 8'h41};
		send_string();
		// stray continuation mid-string
		string_bytes = '{8'h41, 8'hBF, 8'h41};
		send_string();
		string_bytes = '{8'hC3, 8'h41};
		send_string();
		string_bytes = '{8'hE2, 8'h41, 8'h82};
		send_string();
		string_bytes = '{8'hF0, 8'h90, 8'h41, 8'h80};
		send_string();
		// mis-encoded and cut off reports truncation
		string_bytes = '{8'hE2, 8'h41};
		send_string();
		// lead on the last byte
		string_bytes = '{8'hC3};
		send_string();
		quiesce();
		write_ascii_only(1'b1);
		string_bytes = '{8'h41, 8'hC3};
		send_string();
		quiesce();
		write_ascii_only(1'b0);
	endtask

	task automatic test_mode_switch_mid_string();
		quiesce();
		send_byte(8'hC3, 1'b0);
		quiesce();
		write_ascii_only(1'b1);
		send_byte(8'hA9, 1'b1);
		quiesce();
		write_ascii_only(1'b0);
	endtask

	task automatic test_random_strings(input int budget, input int src_pct, input int snk_pct);
		int seg_end;
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
		for (int seg = 0; seg < 3; seg++) begin
			quiesce();
			write_ascii_only(seg == 1);
			seg_end = bytes_sent + budget / 3;
			while (bytes_sent < seg_end) begin
				build_random_string(seg == 1 && $urandom_range(0, 3) != 0);
				send_string();
				if ($urandom_range(0, 19) == 0)
					drain();
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_utf8();
		test_mode_switch_mid_string();
		test_random_strings(650, 20, 80);
		test_random_strings(650, 80, 20);
		test_random_strings(650, 0, 0);
		quiesce();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && decoded_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
